### rtl/cws_pkg.sv
// ----------------------------------------------------------------------------
// cws_pkg: shared types and constants for the column width search block
// Command codes, sequencer states and the result record that passes from
// the search engine to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cws_pkg;

  // Default table depth in columns.
  localparam int MaxColumnsDef = 1024;

  // Fixed field widths.
  localparam int WidthW = 16;
  localparam int ResW   = 11;

  // Command codes carried on the input stream.
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_NEAREST = 2'd2,
    CMD_WRAP    = 2'd3
  } cws_cmd_e;

  // Search sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N_FIRST,
    ST_N_LAST,
    ST_N_ADDR,
    ST_N_CMP,
    ST_N_UP,
    ST_N_DN,
    ST_W_ADDR,
    ST_W_CMP,
    ST_DONE
  } cws_state_e;

  // One search answer.
  typedef struct packed {
    logic signed [ResW-1:0] index;
    logic                   no_match;
  } cws_res_t;

  // Answer used when no column qualifies.
  localparam cws_res_t ResNone = '{index: '1, no_match: 1'b1};

endpackage : cws_pkg

`default_nettype wire

### rtl/cws_engine.sv
// ----------------------------------------------------------------------------
// cws_engine: width table and binary search sequencer
// Holds the cumulative width table in a single-port-write, registered-read
// memory and runs both searches through one shared subtract/compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cws_engine #(
  parameter int MAX_COLUMNS = cws_pkg::MaxColumnsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire cws_pkg::cws_cmd_e         cmd_i,
  input  wire logic [cws_pkg::WidthW-1:0] width_i,
  input  wire logic [cws_pkg::WidthW-1:0] wrap_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output cws_pkg::cws_res_t              res_o
);
  import cws_pkg::*;

  localparam int IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CntW = $clog2(MAX_COLUMNS + 1);

  // Table storage.
  logic [WidthW-1:0] mem [MAX_COLUMNS];
  logic [WidthW-1:0] rdata_q;
  logic [IdxW-1:0]   raddr;
  logic              wr_en;

  // Sequencer state and search bounds.
  cws_state_e        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   lo_q, lo_d;
  logic [CntW-1:0]   hi_q, hi_d;
  logic [WidthW-1:0] opnd_q, opnd_d;
  logic [WidthW:0]   up_q, up_d;
  logic [IdxW-1:0]   found_q, found_d;
  logic              found_v_q, found_v_d;
  cws_res_t          res_q, res_d;

  // Shared arithmetic.
  logic [WidthW:0]   diff;
  logic              diff_neg;
  logic              diff_zero;
  logic [WidthW+1:0] tie_sum;
  logic              up_le_dn;
  logic [CntW-1:0]   span;
  logic [CntW-1:0]   mid;
  logic [CntW-1:0]   lo_m1;

  // Table write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IdxW-1:0]] <= width_i;
    end
    rdata_q <= mem[raddr];
  end

  // One subtractor serves every compare: probe width minus operand.
  assign diff      = {1'b0, rdata_q} - {1'b0, opnd_q};
  assign diff_neg  = diff[WidthW];
  assign diff_zero = (diff == '0);

  // Tie break: up <= dn where up = w[lo]-pos and dn = pos-w[lo-1].
  assign tie_sum  = {up_q[WidthW], up_q} + {diff[WidthW], diff};
  assign up_le_dn = tie_sum[WidthW+1] || (tie_sum == '0);

  // Midpoint; the wrap search keeps an exclusive upper bound.
  assign span  = (state_q == ST_W_ADDR || state_q == ST_W_CMP) ?
                 (hi_q - lo_q - CntW'(1)) : (hi_q - lo_q);
  assign mid   = lo_q + (span >> 1);
  assign lo_m1 = lo_q - CntW'(1);

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      found_v_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      found_v_q <= found_v_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    opnd_q  <= opnd_d;
    up_q    <= up_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    opnd_d    = opnd_q;
    up_d      = up_q;
    found_d   = found_q;
    found_v_d = found_v_q;
    res_d     = res_q;
    raddr     = '0;
    wr_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // The first nearest probe is column zero, issued on acceptance.
        raddr = '0;
        if (in_valid_i) begin
          case (cmd_i)
            CMD_CLEAR: begin
              cnt_d = '0;
            end
            CMD_APPEND: begin
              if (cnt_q < CntW'(MAX_COLUMNS)) begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end
            CMD_NEAREST: begin
              opnd_d = width_i;
              if (cnt_q == '0) begin
                res_d   = ResNone;
                state_d = ST_DONE;
              end else begin
                state_d = ST_N_FIRST;
              end
            end
            CMD_WRAP: begin
              opnd_d    = wrap_i;
              lo_d      = '0;
              hi_d      = cnt_q;
              found_v_d = 1'b0;
              state_d   = ST_W_ADDR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_N_FIRST: begin
        // Clamp below the first column.
        if (!diff_neg) begin
          res_d   = '{index: '0, no_match: 1'b0};
          state_d = ST_DONE;
        end else begin
          raddr   = IdxW'(cnt_q - CntW'(1));
          state_d = ST_N_LAST;
        end
      end
      ST_N_LAST: begin
        // Clamp beyond the last column.
        if (diff_neg || diff_zero) begin
          res_d   = '{index: ResW'(cnt_q - CntW'(1)), no_match: 1'b0};
          state_d = ST_DONE;
        end else begin
          lo_d    = '0;
          hi_d    = cnt_q - CntW'(1);
          state_d = ST_N_ADDR;
        end
      end
      ST_N_ADDR: begin
        if (lo_q < hi_q) begin
          raddr   = IdxW'(mid);
          state_d = ST_N_CMP;
        end else if (lo_q == '0) begin
          res_d   = '{index: '0, no_match: 1'b0};
          state_d = ST_DONE;
        end else begin
          raddr   = IdxW'(lo_q);
          state_d = ST_N_UP;
        end
      end
      ST_N_CMP: begin
        if (diff_neg) begin
          lo_d = mid + CntW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = ST_N_ADDR;
      end
      ST_N_UP: begin
        // Keep the distance to the upper neighbor, fetch the lower one.
        up_d    = diff;
        raddr   = IdxW'(lo_m1);
        state_d = ST_N_DN;
      end
      ST_N_DN: begin
        res_d   = '{index: ResW'(up_le_dn ? lo_q : lo_m1), no_match: 1'b0};
        state_d = ST_DONE;
      end
      ST_W_ADDR: begin
        if (lo_q < hi_q) begin
          raddr   = IdxW'(mid);
          state_d = ST_W_CMP;
        end else begin
          if (!found_v_q) begin
            res_d = ResNone;
          end else if (found_q <= IdxW'(1)) begin
            res_d = '{index: ResW'(1), no_match: 1'b0};
          end else begin
            res_d = '{index: ResW'(found_q - IdxW'(1)), no_match: 1'b0};
          end
          state_d = ST_DONE;
        end
      end
      ST_W_CMP: begin
        if (!diff_neg) begin
          found_d   = IdxW'(mid);
          found_v_d = 1'b1;
          hi_d      = mid;
        end else begin
          lo_d = mid + CntW'(1);
        end
        state_d = ST_W_ADDR;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // The no-match flag agrees with the index on every offered answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.no_match == (res_o.index == '1)))
    else $error("cws_engine: no_match disagrees with result index");

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_COLUMNS))
    else $error("cws_engine: entry count beyond table depth");

  // Search bounds stay ordered and inside the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_N_ADDR || state_q == ST_N_CMP || state_q == ST_W_ADDR ||
     state_q == ST_W_CMP) |-> (lo_q <= hi_q && hi_q <= cnt_q))
    else $error("cws_engine: search bounds out of order");

  // An append or clear never leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i == CMD_CLEAR || cmd_i == CMD_APPEND))
    |=> (state_q == ST_IDLE))
    else $error("cws_engine: table update started a search");

endmodule : cws_engine

`default_nettype wire

### rtl/column_width_search_top.sv
// ----------------------------------------------------------------------------
// column_width_search_top: cumulative column width table with searches
// Clear and append update the table; nearest and wrap queries binary-search
// it and return one result request each on the output stream.
// ----------------------------------------------------------------------------
// Each table probe is a read through the memory's registered read port
//   followed by the shared compare unit; every result then passes through
//   the output register.
// Throughput: one item at a time; the next item is taken once the engine is
//   idle, even while a result still waits in the output register.
// Reset: empties the table and clears wrap_width; the memory itself is not
//   cleared since only filled entries are ever read.
`default_nettype none

module column_width_search_top #(
  parameter int MAX_COLUMNS = cws_pkg::MaxColumnsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] width_value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [10:0] result_index, [15:11] zero
  output logic             m_axis_tuser,  // [0] no_match
  // wrap_width register write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  import cws_pkg::*;

  logic [WidthW-1:0] wrap_q;
  logic              res_valid;
  logic              res_ready;
  cws_res_t          res;
  logic              out_valid_q;
  cws_res_t          out_q;

  // wrap_width register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
    end else if (cfg_valid_i) begin
      wrap_q <= cfg_data_i;
    end
  end

  // Search engine.
  cws_engine #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (cws_cmd_e'(s_axis_tuser)),
    .width_i    (s_axis_tdata),
    .wrap_i     (wrap_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: frees the engine as soon as its result is captured.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - ResW){1'b0}}, out_q.index};
  assign m_axis_tuser  = out_q.no_match;

endmodule : column_width_search_top

`default_nettype wire
